/* rtl/tilt_pkg.sv */
// shared widths, limits and arctangent table for the tilt angle pipeline
package tilt_pkg;

  // input sample width
  localparam int SAMPLE_W = 16;
  // sum of two squares, y*y + z*z, up to 2^31
  localparam int SUMSQ_W = 32;
  // integer square root of sumsq * 2^32
  localparam int ROOT_W = 32;
  // partial remainder of the square root
  localparam int REM_W = 35;
  // rotation datapath width
  localparam int CW = 41;
  // angle accumulator width, centidegrees * 2^16
  localparam int AW = 34;
  // fractional bits of the angle accumulator
  localparam int ANGLE_FRAC = 16;
  // rounded angle width before clamping
  localparam int QW = AW - ANGLE_FRAC;
  // operand scaling of raw counts
  localparam int OPER_SHIFT = 20;
  // longest supported rotation table
  localparam int TABLE_LEN = 24;

  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sd9000 <<< ANGLE_FRAC);
  localparam logic signed [QW-1:0] ROLL_LIMIT = QW'(18000);
  localparam logic signed [QW-1:0] PITCH_LIMIT = QW'(9000);

  // atan(2^-i) in centidegrees * 2^16
  localparam logic signed [AW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    34'sd294912000, 34'sd174096719, 34'sd91987925, 34'sd46694507,
    34'sd23437865, 34'sd11730358, 34'sd5866610, 34'sd2933484,
    34'sd1466764, 34'sd733385, 34'sd366693, 34'sd183346,
    34'sd91673, 34'sd45837, 34'sd22918, 34'sd11459,
    34'sd5730, 34'sd2865, 34'sd1432, 34'sd716,
    34'sd358, 34'sd179, 34'sd90, 34'sd45
  };

  // sample that rides along the square root pipeline
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } tilt_side_t;

  // pitch special-case flags
  typedef struct packed {
    logic level;
    logic xpos;
    logic xneg;
  } pitch_flags_t;

endpackage

/* rtl/tilt_sqrt.sv */
// pipelined integer square root, one result bit per stage
module tilt_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [tilt_pkg::SUMSQ_W-1:0] sumsq,
  input  tilt_pkg::tilt_side_t        in_side,
  output logic                        out_valid,
  output logic [tilt_pkg::ROOT_W-1:0] root,
  output tilt_pkg::tilt_side_t        out_side
);
  import tilt_pkg::*;

  logic               vld  [0:ROOT_W];
  logic [REM_W-1:0]   rem  [0:ROOT_W];
  logic [ROOT_W-1:0]  rt   [0:ROOT_W];
  logic [2*ROOT_W-1:0] rad [0:ROOT_W];
  tilt_side_t         side [0:ROOT_W];

  // stage inputs
  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    rt[0]   = '0;
    rad[0]  = {sumsq, 32'b0};
    side[0] = in_side;
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;

    // bring down the next digit pair and try the new root bit
    always_comb begin
      shifted = {rem[j][REM_W-3:0], rad[j][2*K+1 -: 2]};
      trial   = REM_W'({rt[j], 2'b01});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      rad[j+1]  <= rad[j];
      side[j+1] <= side[j];
      if (shifted >= trial) begin
        rem[j+1] <= shifted - trial;
        rt[j+1]  <= {rt[j][ROOT_W-2:0], 1'b1};
      end else begin
        rem[j+1] <= shifted;
        rt[j+1]  <= {rt[j][ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

/* rtl/tilt_cordic.sv */
// pipelined cordic vectoring unit, one micro-rotation per stage
module tilt_cordic #(
  parameter int ITERS = 16,
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [tilt_pkg::CW-1:0] num,
  input  logic signed [tilt_pkg::CW-1:0] den,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic signed [tilt_pkg::AW-1:0] angle,
  output logic [SIDE_W-1:0]              out_side
);
  import tilt_pkg::*;

  localparam int N = (ITERS > TABLE_LEN) ? TABLE_LEN : ITERS;

  logic              vld  [0:N];
  logic              zero [0:N];
  logic signed [CW-1:0] xs [0:N];
  logic signed [CW-1:0] ys [0:N];
  logic signed [AW-1:0] acc [0:N];
  logic [SIDE_W-1:0] side [0:N];

  // pre-rotation of the left half-plane by a quarter turn
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    zero[0] <= (num == '0) && (den == '0);
    side[0] <= in_side;
    if (den[CW-1] && !num[CW-1]) begin
      xs[0]  <= num;
      ys[0]  <= -den;
      acc[0] <= QUARTER_TURN;
    end else if (den[CW-1]) begin
      xs[0]  <= -num;
      ys[0]  <= den;
      acc[0] <= -QUARTER_TURN;
    end else begin
      xs[0]  <= den;
      ys[0]  <= num;
      acc[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      zero[i+1] <= zero[i];
      side[i+1] <= side[i];
      if (!ys[i][CW-1]) begin
        xs[i+1]  <= xs[i] + (ys[i] >>> i);
        ys[i+1]  <= ys[i] - (xs[i] >>> i);
        acc[i+1] <= acc[i] + ATAN_TAB[i];
      end else begin
        xs[i+1]  <= xs[i] - (ys[i] >>> i);
        ys[i+1]  <= ys[i] + (xs[i] >>> i);
        acc[i+1] <= acc[i] - ATAN_TAB[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign angle     = zero[N] ? '0 : acc[N];
  assign out_side  = side[N];

endmodule

/* rtl/accel_tilt_angles.sv */
// top level: roll and pitch from one raw three-axis accelerometer sample
// Fully pipelined: one sample is taken every cycle (busy stays low) and its
// roll and pitch appear later with a one-cycle done strobe. The pipeline
// holds a squaring register, a summing register, a 32-stage square root,
// a quarter-turn stage plus one stage per cordic micro-rotation (iterations
// above 24 count as 24), and a rounding register.
// The receiver cannot stall, so results must be taken when done is high.
module accel_tilt_angles #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [tilt_pkg::SAMPLE_W-1:0]  accel_x,
  input  logic signed [tilt_pkg::SAMPLE_W-1:0]  accel_y,
  input  logic signed [tilt_pkg::SAMPLE_W-1:0]  accel_z,
  output logic                                  done,
  output logic signed [15:0]                    roll_centideg,
  output logic signed [14:0]                    pitch_centideg
);
  import tilt_pkg::*;

  localparam int PW = $bits(pitch_flags_t);

  logic                       sq_valid;
  tilt_side_t                 sq_side;
  logic signed [2*SAMPLE_W-1:0] yy;
  logic signed [2*SAMPLE_W-1:0] zz;
  logic                       sum_valid;
  tilt_side_t                 sum_side;
  logic [SUMSQ_W-1:0]         sumsq;
  logic                       rt_valid;
  logic [ROOT_W-1:0]          root;
  tilt_side_t                 rt_side;
  logic signed [CW-1:0]       roll_num;
  logic signed [CW-1:0]       roll_den;
  logic signed [CW-1:0]       pitch_num;
  logic signed [CW-1:0]       pitch_den;
  pitch_flags_t               flags_in;
  logic                       roll_valid;
  logic signed [AW-1:0]       roll_acc;
  logic [0:0]                 roll_side;
  logic                       pitch_valid;
  logic signed [AW-1:0]       pitch_acc;
  logic [PW-1:0]              pitch_side;
  pitch_flags_t               flags_out;
  logic signed [AW-1:0]       roll_sum;
  logic signed [AW-1:0]       pitch_sum;
  logic signed [QW-1:0]       roll_q;
  logic signed [QW-1:0]       pitch_q;
  logic signed [QW-1:0]       roll_c;
  logic signed [QW-1:0]       pitch_c;

  assign busy = 1'b0;

  // request accepted: square the horizontal axes
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    sq_side <= '{x: accel_x, y: accel_y, z: accel_z};
    yy      <= accel_y * accel_y;
    zz      <= accel_z * accel_z;
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else begin
      sum_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum_side <= sq_side;
    sumsq    <= SUMSQ_W'(yy) + SUMSQ_W'(zz);
  end

  tilt_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .sumsq     (sumsq),
    .in_side   (sum_side),
    .out_valid (rt_valid),
    .root      (root),
    .out_side  (rt_side)
  );

  // cordic operands; a zero root means no horizontal component
  always_comb begin
    roll_num  = CW'(rt_side.y) <<< OPER_SHIFT;
    roll_den  = CW'(rt_side.z) <<< OPER_SHIFT;
    pitch_num = (-CW'(rt_side.x)) <<< OPER_SHIFT;
    pitch_den = CW'({root, 4'b0000});
    flags_in.level = (root == '0);
    flags_in.xpos  = !rt_side.x[SAMPLE_W-1] && (rt_side.x != '0);
    flags_in.xneg  = rt_side.x[SAMPLE_W-1];
  end

  tilt_cordic #(.ITERS(ANGLE_ITERATIONS), .SIDE_W(1)) u_roll (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_valid),
    .num       (roll_num),
    .den       (roll_den),
    .in_side   (1'b0),
    .out_valid (roll_valid),
    .angle     (roll_acc),
    .out_side  (roll_side)
  );

  tilt_cordic #(.ITERS(ANGLE_ITERATIONS), .SIDE_W(PW)) u_pitch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_valid),
    .num       (pitch_num),
    .den       (pitch_den),
    .in_side   (flags_in),
    .out_valid (pitch_valid),
    .angle     (pitch_acc),
    .out_side  (pitch_side)
  );

  // round to nearest and clamp; a level sample takes its pitch from the sign of x
  always_comb begin
    flags_out = pitch_side;
    roll_sum  = roll_acc + AW'(1 << (ANGLE_FRAC - 1));
    pitch_sum = pitch_acc + AW'(1 << (ANGLE_FRAC - 1));
    roll_q    = QW'(roll_sum >>> ANGLE_FRAC);
    pitch_q   = QW'(pitch_sum >>> ANGLE_FRAC);
    if (roll_q > ROLL_LIMIT) begin
      roll_c = ROLL_LIMIT;
    end else if (roll_q < -ROLL_LIMIT) begin
      roll_c = -ROLL_LIMIT;
    end else begin
      roll_c = roll_q;
    end
    if (flags_out.level) begin
      if (flags_out.xpos) begin
        pitch_c = -PITCH_LIMIT;
      end else if (flags_out.xneg) begin
        pitch_c = PITCH_LIMIT;
      end else begin
        pitch_c = '0;
      end
    end else if (pitch_q > PITCH_LIMIT) begin
      pitch_c = PITCH_LIMIT;
    end else if (pitch_q < -PITCH_LIMIT) begin
      pitch_c = -PITCH_LIMIT;
    end else begin
      pitch_c = pitch_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pitch_valid && roll_valid && !roll_side[0];
    end
  end

  always_ff @(posedge clk) begin
    roll_centideg  <= roll_c[15:0];
    pitch_centideg <= pitch_c[14:0];
  end

endmodule
